### rtl/ipu_pkg.sv
package ipu_pkg;

    localparam int CFG_BITS      = 13;
    localparam int CFG_IDX_BITS  = 3;
    localparam int SCALE_BITS    = 4;
    localparam int POS_BITS      = 12;
    localparam int PIXEL_BITS    = 32;
    localparam int SUM_BITS      = 32;
    localparam int OFF_BITS      = 12;
    localparam int SCALED_BITS   = 16;
    localparam int POSF_BITS     = 15;
    localparam int COORD_BITS    = 16;

    localparam int DEF_MAX_SCALE     = 8;
    localparam int DEF_MAX_DIMENSION = 4096;
    localparam int DEF_ADDRESS_BITS  = 24;

    localparam logic [CFG_BITS-1:0]   RST_SOURCE_WIDTH  = 13'd320;
    localparam logic [CFG_BITS-1:0]   RST_SOURCE_HEIGHT = 13'd240;
    localparam logic [SCALE_BITS-1:0] RST_SCALE_FACTOR  = 4'd2;
    localparam logic [CFG_BITS-1:0]   RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [CFG_BITS-1:0]   RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [CFG_BITS-1:0]   RST_ROW_STRIDE    = 13'd640;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_SCALE_FACTOR  = 3'd2,
        CFG_SCREEN_WIDTH  = 3'd3,
        CFG_SCREEN_HEIGHT = 3'd4,
        CFG_ROW_STRIDE    = 3'd5
    } cfg_index_t;

endpackage

### rtl/integer_pixel_upscaler_unit.sv
// An accepted transaction passes two arithmetic stages, the box stage and the output
// register before its first write appears on the result port.
// Each source pixel gives factor*factor writes, one write per cycle while m_ready allows, set by the
// box write sequencer feeding the single output register; at factor 1 one pixel per cycle when not stalled.
// Reset (aresetn, synchronous, active low) empties the pipeline, zeroes the source
// position and loads every configuration register with its default.
module integer_pixel_upscaler_unit #(
    parameter int MAX_SCALE     = ipu_pkg::DEF_MAX_SCALE,
    parameter int MAX_DIMENSION = ipu_pkg::DEF_MAX_DIMENSION,
    parameter int ADDRESS_BITS  = ipu_pkg::DEF_ADDRESS_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_enable,
    input  logic [ipu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ipu_pkg::CFG_BITS-1:0]        cfg_write_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ipu_pkg::PIXEL_BITS-1:0]      s_source_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ADDRESS_BITS-1:0]             m_write_address,
    output logic [ipu_pkg::PIXEL_BITS-1:0]      m_write_pixel,
    output logic                                m_box_last,
    output logic                                m_frame_last
);
    import ipu_pkg::*;

    localparam int CNT_BITS = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam logic [SCALE_BITS-1:0] MAX_F = SCALE_BITS'(MAX_SCALE);
    localparam logic [CFG_BITS-1:0]   MAX_D = CFG_BITS'(MAX_DIMENSION);

    // Configuration registers
    logic [CFG_BITS-1:0]   src_w_reg, src_h_reg, scr_w_reg, scr_h_reg, stride_reg;
    logic [SCALE_BITS-1:0] scale_reg;

    // Running source position
    logic [POS_BITS-1:0] col_reg, row_reg, col_next, row_next;

    // Pipeline stages
    logic                   v1_reg, v2_reg, v3_reg;
    logic [PIXEL_BITS-1:0]  pix1_reg, pix2_reg, pix3_reg;
    logic [POS_BITS-1:0]    col1_reg, row1_reg;
    logic                   last1_reg, last2_reg, last3_reg;
    logic [COORD_BITS-1:0]  ypos2_reg, xsum2_reg, ypos_next, xsum_next;
    logic [ADDRESS_BITS-1:0] row_start_reg;
    logic [CNT_BITS-1:0]    r_cnt_reg, c_cnt_reg;

    // Output register
    logic                    m_valid_reg, m_box_last_reg, m_frame_last_reg;
    logic [ADDRESS_BITS-1:0] m_addr_reg;
    logic [PIXEL_BITS-1:0]   m_pixel_reg;

    // Effective configuration
    logic [SCALE_BITS-1:0] f_eff, f_last;
    logic [CFG_BITS-1:0]   w_eff, h_eff, sw_eff, sh_eff, stride_eff;

    always_comb begin
        if (scale_reg == '0)        f_eff = SCALE_BITS'(1);
        else if (scale_reg > MAX_F) f_eff = MAX_F;
        else                        f_eff = scale_reg;
        f_last = f_eff - SCALE_BITS'(1);
        if (src_w_reg == '0)        w_eff = CFG_BITS'(1);
        else if (src_w_reg > MAX_D) w_eff = MAX_D;
        else                        w_eff = src_w_reg;
        if (src_h_reg == '0)        h_eff = CFG_BITS'(1);
        else if (src_h_reg > MAX_D) h_eff = MAX_D;
        else                        h_eff = src_h_reg;
        sw_eff     = (scr_w_reg > MAX_D) ? MAX_D : scr_w_reg;
        sh_eff     = (scr_h_reg > MAX_D) ? MAX_D : scr_h_reg;
        stride_eff = (stride_reg > MAX_D) ? MAX_D : stride_reg;
    end

    // Handshake chain
    logic s_accept, out_load, c_end, r_end, done3, ready1, ready2, ready3;

    assign c_end    = (SCALE_BITS'(c_cnt_reg) == f_last);
    assign r_end    = (SCALE_BITS'(r_cnt_reg) == f_last);
    assign out_load = v3_reg && (!m_valid_reg || m_ready);
    assign done3    = out_load && c_end && r_end;
    assign ready3   = !v3_reg || done3;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_ready  = ready1;
    assign s_accept = s_valid && ready1;

    // Position of the accepted pixel, wrapped against the current source size.
    logic [CFG_BITS-1:0] row_tmp, col_inc, row_inc;
    logic [POS_BITS-1:0] col_eff, row_eff;
    logic                last_of_frame;

    always_comb begin
        if (CFG_BITS'(col_reg) >= w_eff) begin
            col_eff = '0;
            row_tmp = CFG_BITS'(row_reg) + CFG_BITS'(1);
        end else begin
            col_eff = col_reg;
            row_tmp = CFG_BITS'(row_reg);
        end
        row_eff = (row_tmp >= h_eff) ? '0 : row_tmp[POS_BITS-1:0];
        last_of_frame = (CFG_BITS'(col_eff) == w_eff - CFG_BITS'(1)) &&
                        (CFG_BITS'(row_eff) == h_eff - CFG_BITS'(1));
        col_inc = CFG_BITS'(col_eff) + CFG_BITS'(1);
        row_inc = CFG_BITS'(row_eff) + CFG_BITS'(1);
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[POS_BITS-1:0];
        end else begin
            col_next = col_inc[POS_BITS-1:0];
            row_next = row_eff;
        end
    end

    // Stage 1 arithmetic: centering offsets and scaled source coordinates.
    logic [SCALED_BITS-1:0] scaled_w, scaled_h, diff_w, diff_h;
    logic [OFF_BITS-1:0]    xoff, yoff;
    logic [POSF_BITS-1:0]   rowf, colf;

    always_comb begin
        scaled_w = SCALED_BITS'(f_eff) * SCALED_BITS'(w_eff);
        scaled_h = SCALED_BITS'(f_eff) * SCALED_BITS'(h_eff);
        diff_w   = SCALED_BITS'(sw_eff) - scaled_w;
        diff_h   = SCALED_BITS'(sh_eff) - scaled_h;
        xoff     = (SCALED_BITS'(sw_eff) > scaled_w) ? diff_w[OFF_BITS:1] : '0;
        yoff     = (SCALED_BITS'(sh_eff) > scaled_h) ? diff_h[OFF_BITS:1] : '0;
        rowf     = POSF_BITS'(row1_reg) * POSF_BITS'(f_eff);
        colf     = POSF_BITS'(col1_reg) * POSF_BITS'(f_eff);
        ypos_next = COORD_BITS'(yoff) + COORD_BITS'(rowf);
        xsum_next = COORD_BITS'(xoff) + COORD_BITS'(colf);
    end

    // Stage 2 arithmetic: first address of the box.
    logic [SUM_BITS-1:0] box_addr, row_step, out_addr;

    assign box_addr = SUM_BITS'(ypos2_reg) * SUM_BITS'(stride_eff) + SUM_BITS'(xsum2_reg);
    assign row_step = SUM_BITS'(row_start_reg) + SUM_BITS'(stride_eff);
    assign out_addr = SUM_BITS'(row_start_reg) + SUM_BITS'(c_cnt_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg   <= RST_SOURCE_WIDTH;
            src_h_reg   <= RST_SOURCE_HEIGHT;
            scale_reg   <= RST_SCALE_FACTOR;
            scr_w_reg   <= RST_SCREEN_WIDTH;
            scr_h_reg   <= RST_SCREEN_HEIGHT;
            stride_reg  <= RST_ROW_STRIDE;
            col_reg     <= '0;
            row_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            r_cnt_reg   <= '0;
            c_cnt_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write_enable) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SOURCE_WIDTH:  src_w_reg  <= cfg_write_data;
                    CFG_SOURCE_HEIGHT: src_h_reg  <= cfg_write_data;
                    CFG_SCALE_FACTOR:  scale_reg  <= cfg_write_data[SCALE_BITS-1:0];
                    CFG_SCREEN_WIDTH:  scr_w_reg  <= cfg_write_data;
                    CFG_SCREEN_HEIGHT: scr_h_reg  <= cfg_write_data;
                    CFG_ROW_STRIDE:    stride_reg <= cfg_write_data;
                    default: ;
                endcase
            end
            if (s_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (ready1) v1_reg <= s_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) begin
                v3_reg    <= v2_reg;
                r_cnt_reg <= '0;
                c_cnt_reg <= '0;
            end else if (out_load) begin
                if (c_end) begin
                    c_cnt_reg <= '0;
                    r_cnt_reg <= r_cnt_reg + CNT_BITS'(1);
                end else begin
                    c_cnt_reg <= c_cnt_reg + CNT_BITS'(1);
                end
            end
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix1_reg  <= s_source_pixel;
            col1_reg  <= col_eff;
            row1_reg  <= row_eff;
            last1_reg <= last_of_frame;
        end
        if (ready2) begin
            pix2_reg  <= pix1_reg;
            ypos2_reg <= ypos_next;
            xsum2_reg <= xsum_next;
            last2_reg <= last1_reg;
        end
        if (ready3) begin
            pix3_reg      <= pix2_reg;
            last3_reg     <= last2_reg;
            row_start_reg <= box_addr[ADDRESS_BITS-1:0];
        end else if (out_load && c_end) begin
            row_start_reg <= row_step[ADDRESS_BITS-1:0];
        end
        if (out_load) begin
            m_addr_reg       <= out_addr[ADDRESS_BITS-1:0];
            m_pixel_reg      <= pix3_reg;
            m_box_last_reg   <= c_end && r_end;
            m_frame_last_reg <= c_end && r_end && last3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = m_addr_reg;
    assign m_write_pixel   = m_pixel_reg;
    assign m_box_last      = m_box_last_reg;
    assign m_frame_last    = m_frame_last_reg;

    // The frame marker only ever closes a box.
    a_frame_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_frame_last_reg |-> m_box_last_reg)
        else $error("frame_last without box_last");

    // Box counters never run past the scale factor.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (SCALE_BITS'(c_cnt_reg) < f_eff) && (SCALE_BITS'(r_cnt_reg) < f_eff))
        else $error("box counter beyond scale factor");

    // Input back-pressure only when every stage holds a pixel.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg)
        else $error("input stalled with a free stage");

    // A finished box with nothing behind it leaves the box stage empty.
    a_box_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        done3 && !v2_reg |=> !v3_reg)
        else $error("box stage not released");

endmodule
